/* hw/rtl/grto_pkg.sv */
// ---------------------------------------------------------------------------
// grto_pkg
// Shared types and constants of the grid ray traversal occupancy unit.
// ---------------------------------------------------------------------------
package grto_pkg;

   localparam int MAX_STEPS  = 63;
   localparam int STEP_W     = $clog2(MAX_STEPS + 1);
   localparam int COORD_W    = 32;
   localparam int CS_W       = 16;
   localparam int LO_W       = 16;
   localparam int SCALED_W   = CS_W + COORD_W;
   localparam int BOUND_W    = SCALED_W + STEP_W;
   localparam int DIVCNT_W   = $clog2(COORD_W);
   localparam int CSR_ADDR_W = 4;

   localparam logic [1:0] REG_CELL_SIZE = 2'd0;
   localparam logic [1:0] REG_HIT_LO    = 2'd1;
   localparam logic [1:0] REG_MISS_LO   = 2'd2;

   localparam logic [CS_W-1:0] CELL_SIZE_RST = 16'd50;
   localparam logic [LO_W-1:0] HIT_LO_RST    = 16'd217;
   localparam logic [LO_W-1:0] MISS_LO_RST   = 16'hFF98;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SCALE,
      ST_SETUP,
      ST_WALK,
      ST_HIT
   } state_type;

   typedef struct packed {
      logic idle;
      logic div_step;
      logic scale;
      logic setup;
      logic walk;
      logic hit;
   } cmd_type;

   typedef struct packed {
      logic start_ok;
      logic div_last;
      logic walk_done;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [CS_W-1:0] cell_size;
      logic [LO_W-1:0] hit_ev;
      logic [LO_W-1:0] miss_ev;
   } cfg_type;

endpackage

/* hw/rtl/grto_if.sv */
// ---------------------------------------------------------------------------
// grto_req_if / grto_rsp_if
// Valid/ready channels for lidar points and traversed cells.
// ---------------------------------------------------------------------------
interface grto_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic               point_valid;

   modport source (output valid, point_x, point_y, point_valid, input ready);
   modport sink   (input valid, point_x, point_y, point_valid, output ready);
endinterface

interface grto_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] cell_x;
   logic signed [31:0] cell_y;
   logic               is_hit;
   logic signed [15:0] evidence;
   logic               truncated;
   logic               last;

   modport source (output valid, cell_x, cell_y, is_hit, evidence, truncated, last,
                   input ready);
   modport sink   (input valid, cell_x, cell_y, is_hit, evidence, truncated, last,
                   output ready);
endinterface

/* hw/rtl/grto_csr.sv */
// ---------------------------------------------------------------------------
// grto_csr
// APB register file: cell size and hit/miss log-odds.
// ---------------------------------------------------------------------------
module grto_csr
   import grto_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[3:2])
            REG_CELL_SIZE: cfg_in.cell_size = csr_pwdata[CS_W-1:0];
            REG_HIT_LO:    cfg_in.hit_ev    = csr_pwdata[LO_W-1:0];
            REG_MISS_LO:   cfg_in.miss_ev   = csr_pwdata[LO_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_CELL_SIZE: csr_prdata = {16'd0, cfg_ff.cell_size};
         REG_HIT_LO:    csr_prdata = {16'd0, cfg_ff.hit_ev};
         REG_MISS_LO:   csr_prdata = {16'd0, cfg_ff.miss_ev};
         default:       csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{cell_size: CELL_SIZE_RST, hit_ev: HIT_LO_RST,
                     miss_ev: MISS_LO_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/grto_ctrl.sv */
// ---------------------------------------------------------------------------
// grto_ctrl
// Sequencer: divide, scale, set up, walk the ray, then the hit cell.
// ---------------------------------------------------------------------------
module grto_ctrl
   import grto_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_fire,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire && status.start_ok) state_in = ST_DIVIDE;
         ST_DIVIDE: if (status.div_last) state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_SETUP;
         ST_SETUP:  state_in = ST_WALK;
         ST_WALK:   if (status.walk_done) state_in = ST_HIT;
         ST_HIT:    if (status.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:   cmd.idle     = 1'b1;
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_SCALE:  cmd.scale    = 1'b1;
         ST_SETUP:  cmd.setup    = 1'b1;
         ST_WALK:   cmd.walk     = 1'b1;
         ST_HIT:    cmd.hit      = 1'b1;
         default:   cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/grto_dp.sv */
// ---------------------------------------------------------------------------
// grto_dp
// Datapath: two restoring dividers, boundary scaling, DDA walker, output reg.
// ---------------------------------------------------------------------------
module grto_dp
   import grto_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output status_type    status,
   input  cfg_type       cfg,
   grto_req_if.sink      req_chan,
   grto_rsp_if.source    rsp_chan
);

   // division state
   logic [COORD_W-1:0]  qx_ff, qx_in, qy_ff, qy_in;
   logic [CS_W-1:0]     rx_ff, rx_in, ry_ff, ry_in;
   logic [DIVCNT_W-1:0] dcnt_ff, dcnt_in;
   logic                negx_ff, negx_in, negy_ff, negy_in;
   logic                posx_ff, posx_in, posy_ff, posy_in;
   // ray geometry
   logic [COORD_W-1:0]  ax_ff, ax_in, ay_ff, ay_in;
   logic [COORD_W-1:0]  magx_ff, magx_in, magy_ff, magy_in;
   logic [COORD_W-1:0]  tx_ff, tx_in, ty_ff, ty_in;
   logic [SCALED_W-1:0] csax_ff, csax_in, csay_ff, csay_in;
   logic [BOUND_W-1:0]  bndx_ff, bndx_in, bndy_ff, bndy_in;
   logic [COORD_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic [STEP_W-1:0]   i_ff, i_in, emit_ff, emit_in;
   logic                trunc_ff, trunc_in;
   // output register
   logic                ov_ff, ov_in;
   logic [COORD_W-1:0]  ocx_ff, ocx_in, ocy_ff, ocy_in;
   logic                ohit_ff, ohit_in, olast_ff, olast_in, otr_ff, otr_in;
   logic [LO_W-1:0]     olo_ff, olo_in;

   logic [CS_W:0]       tx_r, ty_r;
   logic                gex, gey;
   logic [COORD_W:0]    n_sum, n_miss;
   logic                out_free, step, stepx;
   logic [COORD_W-1:0]  x_nx, y_nx;

   assign out_free = !ov_ff || rsp_chan.ready;
   assign step     = cmd.walk && (i_ff != emit_ff) && out_free;

   assign status.start_ok  = req_chan.point_valid && (cfg.cell_size != '0);
   assign status.div_last  = (dcnt_ff == DIVCNT_W'(COORD_W - 1));
   assign status.walk_done = (i_ff == emit_ff);
   assign status.out_free  = out_free;

   assign req_chan.ready = cmd.idle;

   // one quotient bit per cycle on each axis
   assign tx_r = {rx_ff, qx_ff[COORD_W-1]};
   assign ty_r = {ry_ff, qy_ff[COORD_W-1]};
   assign gex  = tx_r >= {1'b0, cfg.cell_size};
   assign gey  = ty_r >= {1'b0, cfg.cell_size};

   assign n_sum  = {1'b0, magx_ff} + {1'b0, magy_ff};
   assign n_miss = (n_sum == '0) ? '0 : n_sum - 1'b1;

   always_comb begin
      if (x_ff == tx_ff) begin
         stepx = 1'b0;
      end else if (y_ff == ty_ff) begin
         stepx = 1'b1;
      end else begin
         stepx = bndx_ff < bndy_ff;
      end
      x_nx = negx_ff ? x_ff - 1'b1 : x_ff + 1'b1;
      y_nx = negy_ff ? y_ff - 1'b1 : y_ff + 1'b1;
   end

   always_comb begin
      qx_in = qx_ff;   qy_in = qy_ff;   rx_in = rx_ff;   ry_in = ry_ff;
      dcnt_in = dcnt_ff;
      negx_in = negx_ff; negy_in = negy_ff; posx_in = posx_ff; posy_in = posy_ff;
      ax_in = ax_ff;   ay_in = ay_ff;
      magx_in = magx_ff; magy_in = magy_ff; tx_in = tx_ff; ty_in = ty_ff;
      csax_in = csax_ff; csay_in = csay_ff; bndx_in = bndx_ff; bndy_in = bndy_ff;
      x_in = x_ff;     y_in = y_ff;     i_in = i_ff;     emit_in = emit_ff;
      trunc_in = trunc_ff;
      ov_in = out_free ? 1'b0 : ov_ff;
      ocx_in = ocx_ff; ocy_in = ocy_ff; ohit_in = ohit_ff; olast_in = olast_ff;
      otr_in = otr_ff; olo_in = olo_ff;

      if (cmd.idle) begin
         negx_in = req_chan.point_x < 0;
         negy_in = req_chan.point_y < 0;
         posx_in = req_chan.point_x > 0;
         posy_in = req_chan.point_y > 0;
         ax_in   = req_chan.point_x[31] ? 32'(-req_chan.point_x) : req_chan.point_x;
         ay_in   = req_chan.point_y[31] ? 32'(-req_chan.point_y) : req_chan.point_y;
         qx_in   = ax_in;
         qy_in   = ay_in;
         rx_in   = '0;
         ry_in   = '0;
         dcnt_in = '0;
      end

      if (cmd.div_step) begin
         rx_in   = gex ? CS_W'(tx_r - {1'b0, cfg.cell_size}) : tx_r[CS_W-1:0];
         ry_in   = gey ? CS_W'(ty_r - {1'b0, cfg.cell_size}) : ty_r[CS_W-1:0];
         qx_in   = {qx_ff[COORD_W-2:0], gex};
         qy_in   = {qy_ff[COORD_W-2:0], gey};
         dcnt_in = dcnt_ff + 1'b1;
      end

      if (cmd.scale) begin
         // floor toward minus infinity for negative coordinates
         magx_in = qx_ff + COORD_W'(negx_ff && (rx_ff != '0));
         magy_in = qy_ff + COORD_W'(negy_ff && (ry_ff != '0));
         tx_in   = negx_ff ? -magx_in : magx_in;
         ty_in   = negy_ff ? -magy_in : magy_in;
         csax_in = {{COORD_W{1'b0}}, cfg.cell_size} * {{CS_W{1'b0}}, ax_ff};
         csay_in = {{COORD_W{1'b0}}, cfg.cell_size} * {{CS_W{1'b0}}, ay_ff};
      end

      if (cmd.setup) begin
         trunc_in = n_miss > (COORD_W+1)'(MAX_STEPS);
         emit_in  = trunc_in ? STEP_W'(MAX_STEPS) : n_miss[STEP_W-1:0];
         // bx*|y| and by*|x| kept as running sums
         bndx_in  = posx_ff ? BOUND_W'(csay_ff) : '0;
         bndy_in  = posy_ff ? BOUND_W'(csax_ff) : '0;
         x_in     = '0;
         y_in     = '0;
         i_in     = '0;
      end

      if (step) begin
         if (stepx) begin
            x_in    = x_nx;
            bndx_in = bndx_ff + BOUND_W'(csay_ff);
         end else begin
            y_in    = y_nx;
            bndy_in = bndy_ff + BOUND_W'(csax_ff);
         end
         i_in     = i_ff + 1'b1;
         ov_in    = cfg.miss_ev != '0;
         ocx_in   = x_in;
         ocy_in   = y_in;
         ohit_in  = 1'b0;
         olo_in   = cfg.miss_ev;
         otr_in   = trunc_ff;
         olast_in = (cfg.hit_ev == '0) && (i_in == emit_ff);
      end

      if (cmd.hit && out_free) begin
         ov_in    = cfg.hit_ev != '0;
         ocx_in   = tx_ff;
         ocy_in   = ty_ff;
         ohit_in  = 1'b1;
         olo_in   = cfg.hit_ev;
         otr_in   = trunc_ff;
         olast_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff   <= 1'b0;
         i_ff    <= '0;
         emit_ff <= '0;
         dcnt_ff <= '0;
      end else begin
         ov_ff   <= ov_in;
         i_ff    <= i_in;
         emit_ff <= emit_in;
         dcnt_ff <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff <= qx_in;     qy_ff <= qy_in;     rx_ff <= rx_in;     ry_ff <= ry_in;
      negx_ff <= negx_in; negy_ff <= negy_in; posx_ff <= posx_in; posy_ff <= posy_in;
      ax_ff <= ax_in;     ay_ff <= ay_in;
      magx_ff <= magx_in; magy_ff <= magy_in; tx_ff <= tx_in;     ty_ff <= ty_in;
      csax_ff <= csax_in; csay_ff <= csay_in; bndx_ff <= bndx_in; bndy_ff <= bndy_in;
      x_ff <= x_in;       y_ff <= y_in;       trunc_ff <= trunc_in;
      ocx_ff <= ocx_in;   ocy_ff <= ocy_in;   ohit_ff <= ohit_in;
      olast_ff <= olast_in; otr_ff <= otr_in; olo_ff <= olo_in;
   end

   assign rsp_chan.valid     = ov_ff;
   assign rsp_chan.cell_x    = ocx_ff;
   assign rsp_chan.cell_y    = ocy_ff;
   assign rsp_chan.is_hit    = ohit_ff;
   assign rsp_chan.evidence  = olo_ff;
   assign rsp_chan.truncated = otr_ff;
   assign rsp_chan.last      = olast_ff;

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      i_ff <= emit_ff)
      else $error("walk count ran past the miss count");

   a_hit_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.is_hit |-> rsp_chan.last)
      else $error("hit cell not marked last");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      step |-> out_free)
      else $error("walk step while output register full");

endmodule

/* hw/rtl/grid_ray_traversal_occupancy_unit.sv */
// ---------------------------------------------------------------------------
// grid_ray_traversal_occupancy_unit
// Casts a 2D grid ray from cell (0,0) to a lidar point's cell.
// ---------------------------------------------------------------------------
// usage:
//   req_chan carries one point (x, y in mm, point_valid). rsp_chan returns
//   the cells crossed, in walk order, as misses, then the target cell as a
//   hit; last marks the final cell of a point. csr_* is an APB port for
//   cell_size (0x0), hit evidence (0x4) and miss evidence (0x8).
// processing:
//   one point at a time. restoring division on both axes in parallel (one
//   quotient bit a cycle), then a scaling multiply, then setup, then one
//   cell per cycle, the output permitting, for up to 63 misses and one hit.
//   a dropped point (point_valid low or cell_size zero) is accepted and
//   produces nothing.
// reset:
//   synchronous; registers return to 50 / 217 / -104, no transaction pending.
// stalls:
//   the walk holds whenever the output register is full and rsp_chan.ready
//   is low; no cell is lost.
// ---------------------------------------------------------------------------
module grid_ray_traversal_occupancy_unit
   import grto_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   grto_req_if.sink              req_chan,
   grto_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   logic       req_fire;

   assign req_fire = req_chan.valid && req_chan.ready;

   grto_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   grto_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .status   (status),
      .cmd      (cmd)
   );

   grto_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule
